// ===== sv/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared constants for the sync-header frame builder: sync bytes, length
// offset, header layout and the default payload capacity.
// ----------------------------------------------------------------------------
package sfb_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 16;

   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
   localparam logic [BYTE_W-1:0] LEN_EXTRA   = 8'd3;

   // header positions within the outgoing frame
   localparam int HDR_BYTES = 5;
   localparam logic [2:0] HDR_SYNC1 = 3'd0;
   localparam logic [2:0] HDR_SYNC2 = 3'd1;
   localparam logic [2:0] HDR_LEN   = 3'd2;
   localparam logic [2:0] HDR_CHK   = 3'd3;
   localparam logic [2:0] HDR_CMD   = 3'd4;

endpackage

// ===== sv/sfb_ram.sv =====
// ----------------------------------------------------------------------------
// sfb_ram
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfb_ram #(
   parameter int DEPTH = sfb_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [sfb_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [sfb_pkg::BYTE_W-1:0] rd_data
);

   logic [sfb_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [sfb_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfb_ctrl
// Frame sequencer: stores incoming bytes, keeps count and running sum, then
// walks the header and replays the buffer through a registered output stage.
// ----------------------------------------------------------------------------
module sfb_ctrl #(
   parameter int MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [sfb_pkg::CMD_W-1:0]  req_command_code,
   input  logic [sfb_pkg::BYTE_W-1:0] req_payload_byte,
   input  logic                       req_payload_last,
   output logic                       rsp_strobe,
   output logic [sfb_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                       rsp_frame_end,
   output logic                       ram_wr_en,
   output logic [AW-1:0]              ram_wr_addr,
   output logic [sfb_pkg::BYTE_W-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic [AW-1:0]              ram_rd_addr,
   input  logic [sfb_pkg::BYTE_W-1:0] ram_rd_data
);

   localparam int CW = $clog2(MAX_PAYLOAD + 1);
   localparam int IW = $clog2(MAX_PAYLOAD + sfb_pkg::HDR_BYTES);

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type                  state_ff,   state_in;
   logic [IW-1:0]              idx_ff,     idx_in;
   logic [CW-1:0]              count_ff,   count_in;
   logic [sfb_pkg::BYTE_W-1:0] sum_ff,     sum_in;
   logic [sfb_pkg::CMD_W-1:0]  cmd_ff,     cmd_in;
   logic                       strobe_ff,  strobe_in;
   logic                       src_ram_ff, src_ram_in;
   logic [sfb_pkg::BYTE_W-1:0] hdr_ff,     hdr_in;
   logic                       end_ff,     end_in;

   logic          accept;
   logic          room;
   logic [IW-1:0] last_idx;
   logic          in_header;
   logic [IW-1:0] pay_idx;

   assign accept    = start && (state_ff == ST_IDLE);
   assign room      = count_ff < CW'(MAX_PAYLOAD);
   assign last_idx  = IW'(count_ff) + IW'(sfb_pkg::HDR_BYTES - 1);
   assign in_header = idx_ff < IW'(sfb_pkg::HDR_BYTES);
   assign pay_idx   = idx_ff - IW'(sfb_pkg::HDR_BYTES);

   assign ram_wr_en   = accept && room;
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = req_payload_byte;
   assign ram_rd_en   = (state_ff == ST_EMIT) && !in_header;
   assign ram_rd_addr = pay_idx[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      cmd_in     = cmd_ff;
      strobe_in  = 1'b0;
      src_ram_in = 1'b0;
      hdr_in     = hdr_ff;
      end_in     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // drop the byte once the buffer is full
               if (room) begin
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + req_payload_byte;
               end
               if (req_payload_last) begin
                  cmd_in   = req_command_code;
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            strobe_in  = 1'b1;
            src_ram_in = !in_header;
            end_in     = (idx_ff == last_idx);
            case (idx_ff[2:0])
               sfb_pkg::HDR_SYNC1: hdr_in = sfb_pkg::SYNC_FIRST;
               sfb_pkg::HDR_SYNC2: hdr_in = sfb_pkg::SYNC_SECOND;
               sfb_pkg::HDR_LEN:   hdr_in = sfb_pkg::BYTE_W'(count_ff) + sfb_pkg::LEN_EXTRA;
               sfb_pkg::HDR_CHK:   hdr_in = sum_ff + sfb_pkg::BYTE_W'(cmd_ff);
               sfb_pkg::HDR_CMD:   hdr_in = sfb_pkg::BYTE_W'(cmd_ff);
               default:            hdr_in = hdr_ff;
            endcase
            if (idx_ff == last_idx) begin
               count_in = '0;
               sum_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sum_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         strobe_ff <= strobe_in;
      end
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      src_ram_ff <= src_ram_in;
      hdr_ff     <= hdr_in;
      end_ff     <= end_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_frame_byte = src_ram_ff ? ram_rd_data : hdr_ff;
   assign rsp_frame_end  = end_ff;

endmodule

// ===== sv/sync_frame_builder_sum8.sv =====
// ----------------------------------------------------------------------------
// sync_frame_builder_sum8
// Collects payload bytes and emits a sync-header frame with an 8-bit
// additive checksum.
// ----------------------------------------------------------------------------
// A byte without the last flag is taken and busy stays low. On the last
// byte the block raises busy (n bytes stored, at most MAX_PAYLOAD) and emits
// one frame byte per cycle on rsp_strobe, the first once the transfer has
// passed state_ff and the output registers: AA, 55, n + 3, checksum,
// command, then the payload replayed from the buffer, whose single read port
// sets the one-byte-per-cycle replay. The receiver cannot stall: every strobed
// byte must be taken in its cycle. Bytes beyond MAX_PAYLOAD are dropped.
// ----------------------------------------------------------------------------
module sync_frame_builder_sum8 #(
   parameter int MAX_PAYLOAD = sfb_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [sfb_pkg::CMD_W-1:0]  req_command_code,
   input  logic [sfb_pkg::BYTE_W-1:0] req_payload_byte,
   input  logic                       req_payload_last,
   output logic                       rsp_strobe,
   output logic [sfb_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                       rsp_frame_end
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [sfb_pkg::BYTE_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [sfb_pkg::BYTE_W-1:0] ram_rd_data;

   sfb_ctrl #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command_code (req_command_code),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

   sfb_ram #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sync_frame_builder_sum8. A table of directed payloads runs
// first, then random frames of random length, some overflowing the buffer.
// Each frame the block emits is compared byte by byte against frames built
// from a local payload copy and running sum, or typed-in header bytes.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_PAYLOAD  = sfb_pkg::MAX_PAYLOAD_DEFAULT;
   localparam int RANDOM_ITEMS = 135;
   localparam int QUIET_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic [sfb_pkg::BYTE_W-1:0] data;
      logic                       last;
   } frame_beat_type;

   // header bytes are typed in only where they can be read off directly
   typedef struct packed {
      logic [sfb_pkg::CMD_W-1:0]  cmd;
      logic [sfb_pkg::BYTE_W-1:0] data;
      logic                       last;
      logic                       known;
      logic [sfb_pkg::BYTE_W-1:0] len;
      logic [sfb_pkg::BYTE_W-1:0] chk;
   } stim_row_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [sfb_pkg::CMD_W-1:0]    req_command_code = '0;
   logic [sfb_pkg::BYTE_W-1:0]   req_payload_byte = '0;
   logic                         req_payload_last = 1'b0;
   logic                         rsp_strobe;
   logic [sfb_pkg::BYTE_W-1:0]   rsp_frame_byte;
   logic                         rsp_frame_end;

   // typed header values travel alongside the transfer they belong to
   logic                         hdr_known = 1'b0;
   logic [sfb_pkg::BYTE_W-1:0]   hdr_len = '0;
   logic [sfb_pkg::BYTE_W-1:0]   hdr_chk = '0;

   logic [sfb_pkg::BYTE_W-1:0]   payload_copy [MAX_PAYLOAD];
   int                           stored_count = 0;
   logic [sfb_pkg::BYTE_W-1:0]   byte_total = '0;
   frame_beat_type               pending_beats [$];
   int                           fail_count = 0;
   logic                         no_gaps = 1'b0;

   stim_row_type directed_rows [25] = '{
      '{3'd0, 8'h00, 1'b1, 1'b1, 8'h04, 8'h00},   // straight after reset
      '{3'd4, 8'hFF, 1'b1, 1'b1, 8'h04, 8'h03},   // checksum wraps
      '{3'd7, 8'h01, 1'b1, 1'b1, 8'h04, 8'h08},   // largest command code
      '{3'd5, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd1, 8'h7F, 1'b1, 1'b1, 8'h05, 8'h00},
      '{3'd3, 8'h5A, 1'b1, 1'b0, 8'h00, 8'h00},
      '{3'd6, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd2, 8'hAA, 1'b1, 1'b0, 8'h00, 8'h00},
      // fill the buffer, then a last byte that must be dropped
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd7, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{3'd2, 8'h00, 1'b1, 1'b1, 8'h13, 8'hF2}
   };

   sync_frame_builder_sum8 #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command_code (req_command_code),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // store and sum a byte unless the buffer is already full
   function automatic void absorb_byte(input logic [sfb_pkg::BYTE_W-1:0] b);
      if (stored_count < MAX_PAYLOAD) begin
         payload_copy[stored_count] = b;
         stored_count++;
         byte_total = byte_total + b;
      end
   endfunction

   function automatic void queue_frame(input logic [sfb_pkg::CMD_W-1:0] cmd,
                                       input logic known,
                                       input logic [sfb_pkg::BYTE_W-1:0] len,
                                       input logic [sfb_pkg::BYTE_W-1:0] chk);
      logic [sfb_pkg::BYTE_W-1:0] len_byte;
      logic [sfb_pkg::BYTE_W-1:0] chk_byte;
      len_byte = sfb_pkg::BYTE_W'(stored_count) + sfb_pkg::LEN_EXTRA;
      chk_byte = sfb_pkg::BYTE_W'(cmd) + byte_total;
      if (known) begin
         len_byte = len;
         chk_byte = chk;
      end
      pending_beats.push_back(frame_beat_type'{sfb_pkg::SYNC_FIRST, 1'b0});
      pending_beats.push_back(frame_beat_type'{sfb_pkg::SYNC_SECOND, 1'b0});
      pending_beats.push_back(frame_beat_type'{len_byte, 1'b0});
      pending_beats.push_back(frame_beat_type'{chk_byte, 1'b0});
      pending_beats.push_back(frame_beat_type'{sfb_pkg::BYTE_W'(cmd), stored_count == 0});
      for (int i = 0; i < stored_count; i++)
         pending_beats.push_back(frame_beat_type'{payload_copy[i], i == stored_count - 1});
      stored_count = 0;
      byte_total = '0;
   endfunction

   // check strobed bytes first, then record the transfer of this edge
   always @(posedge clock) begin : track_frames
      frame_beat_type due;
      if (!reset && rsp_strobe) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected frame byte, expected none, actual %02h end %0b",
                     $time, rsp_frame_byte, rsp_frame_end);
            fail_count++;
         end else begin
            due = pending_beats.pop_front();
            if (rsp_frame_byte !== due.data) begin
               $display("%0t: frame_byte expected %02h actual %02h",
                        $time, due.data, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_frame_end !== due.last) begin
               $display("%0t: frame_end expected %0b actual %0b",
                        $time, due.last, rsp_frame_end);
               fail_count++;
            end
         end
      end
      if (!reset && start && !busy) begin
         absorb_byte(req_payload_byte);
         if (req_payload_last)
            queue_frame(req_command_code, hdr_known, hdr_len, hdr_chk);
      end
   end

   task automatic send_byte(input logic [sfb_pkg::CMD_W-1:0] cmd,
                            input logic [sfb_pkg::BYTE_W-1:0] data,
                            input logic last, input logic known,
                            input logic [sfb_pkg::BYTE_W-1:0] len,
                            input logic [sfb_pkg::BYTE_W-1:0] chk);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_command_code <= cmd;
      req_payload_byte <= data;
      req_payload_last <= last;
      hdr_known        <= known;
      hdr_len          <= len;
      hdr_chk          <= chk;
      do @(posedge clock); while (!(start && !busy));
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe)
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int frame_len;
      int random_items;
      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_byte(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].last,
                   directed_rows[r].known, directed_rows[r].len, directed_rows[r].chk);

      // mostly frames that fit, now and then one that overflows the buffer
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0)
            frame_len = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 4);
         else
            frame_len = $urandom_range(1, MAX_PAYLOAD);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < frame_len; k++) begin
            send_byte(sfb_pkg::CMD_W'($urandom_range(0, 7)),
                      sfb_pkg::BYTE_W'($urandom_range(0, 255)),
                      k == frame_len - 1, 1'b0, '0, '0);
            random_items++;
         end
      end
      start <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
